>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the scancode FIFO unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clk edge outside of reset.
// The enclosing scope must provide clk and arst_n.
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	`ASSERT_PROP(label, (ante) |-> (cons), msg)

`endif

>>> rtl/scaf_pkg.sv
// Package with the constants, types and key tables of the scancode FIFO unit.
package scaf_pkg;

	localparam int BUF_DEPTH_DEF = 256;

	localparam logic       SC_RELEASE_BIT = 1'b1;
	localparam logic [6:0] SC_LSHIFT      = 7'h2A;
	localparam logic [6:0] SC_RSHIFT      = 7'h36;
	localparam logic [6:0] SC_CAPS        = 7'h3A;
	localparam int         CHAR_W         = 7;

	typedef enum logic {
		OP_SCAN = 1'b0,
		OP_READ = 1'b1
	} op_t;

	// Per-word result flags handed from the decode engine to the output stages.
	typedef struct packed {
		logic char_valid;
		logic buffer_nonempty;
		logic char_dropped;
	} step_flags_t;

	// Set-1 make code to ASCII. Zero means the key yields no character.
	function automatic logic [CHAR_W-1:0] keymap(input logic [6:0] code,
			input logic shifted);
		logic [13:0] pair;
		pair = 14'h0;
		case (code)
			7'h01: pair = {7'h1B, 7'h1B};
			7'h02: pair = {7'h31, 7'h21};
			7'h03: pair = {7'h32, 7'h40};
			7'h04: pair = {7'h33, 7'h23};
			7'h05: pair = {7'h34, 7'h24};
			7'h06: pair = {7'h35, 7'h25};
			7'h07: pair = {7'h36, 7'h5E};
			7'h08: pair = {7'h37, 7'h26};
			7'h09: pair = {7'h38, 7'h2A};
			7'h0A: pair = {7'h39, 7'h28};
			7'h0B: pair = {7'h30, 7'h29};
			7'h0C: pair = {7'h2D, 7'h5F};
			7'h0D: pair = {7'h3D, 7'h2B};
			7'h0E: pair = {7'h08, 7'h08};
			7'h0F: pair = {7'h09, 7'h09};
			7'h10: pair = {7'h71, 7'h51};
			7'h11: pair = {7'h77, 7'h57};
			7'h12: pair = {7'h65, 7'h45};
			7'h13: pair = {7'h72, 7'h52};
			7'h14: pair = {7'h74, 7'h54};
			7'h15: pair = {7'h79, 7'h59};
			7'h16: pair = {7'h75, 7'h55};
			7'h17: pair = {7'h69, 7'h49};
			7'h18: pair = {7'h6F, 7'h4F};
			7'h19: pair = {7'h70, 7'h50};
			7'h1A: pair = {7'h5B, 7'h7B};
			7'h1B: pair = {7'h5D, 7'h7D};
			7'h1C: pair = {7'h0A, 7'h0A};
			7'h1E: pair = {7'h61, 7'h41};
			7'h1F: pair = {7'h73, 7'h53};
			7'h20: pair = {7'h64, 7'h44};
			7'h21: pair = {7'h66, 7'h46};
			7'h22: pair = {7'h67, 7'h47};
			7'h23: pair = {7'h68, 7'h48};
			7'h24: pair = {7'h6A, 7'h4A};
			7'h25: pair = {7'h6B, 7'h4B};
			7'h26: pair = {7'h6C, 7'h4C};
			7'h27: pair = {7'h3B, 7'h3A};
			7'h28: pair = {7'h27, 7'h22};
			7'h29: pair = {7'h60, 7'h7E};
			7'h2B: pair = {7'h5C, 7'h7C};
			7'h2C: pair = {7'h7A, 7'h5A};
			7'h2D: pair = {7'h78, 7'h58};
			7'h2E: pair = {7'h63, 7'h43};
			7'h2F: pair = {7'h76, 7'h56};
			7'h30: pair = {7'h62, 7'h42};
			7'h31: pair = {7'h6E, 7'h4E};
			7'h32: pair = {7'h6D, 7'h4D};
			7'h33: pair = {7'h2C, 7'h3C};
			7'h34: pair = {7'h2E, 7'h3E};
			7'h35: pair = {7'h2F, 7'h3F};
			7'h37: pair = {7'h2A, 7'h2A};
			7'h39: pair = {7'h20, 7'h20};
			default: pair = 14'h0;
		endcase
		return shifted ? pair[6:0] : pair[13:7];
	endfunction

endpackage

>>> rtl/scaf_in_if.sv
// Input channel: one scancode or read request per word.
interface scaf_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] scan_byte;

	modport source (output valid, output opcode, output scan_byte, input ready);
	modport sink (input valid, input opcode, input scan_byte, output ready);
endinterface

>>> rtl/scaf_out_if.sv
// Output channel: one result word per accepted input word.
interface scaf_out_if;
	logic       valid;
	logic       ready;
	logic       char_valid;
	logic [6:0] char_code;
	logic       buffer_nonempty;
	logic       char_dropped;

	modport source (output valid, output char_valid, output char_code,
		output buffer_nonempty, output char_dropped, input ready);
	modport sink (input valid, input char_valid, input char_code,
		input buffer_nonempty, input char_dropped, output ready);
endinterface

>>> rtl/scaf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scaf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/scaf_engine.sv
// Decode engine: shift and caps state, key lookup and ring pointer control.
module scaf_engine import scaf_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF,
	localparam int PTR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              opcode,
	input  logic [7:0]        scan_byte,
	output step_flags_t       flags,
	output logic              wr_en,
	output logic [PTR_W-1:0]  wr_addr,
	output logic [CHAR_W-1:0] wr_data,
	output logic              rd_en,
	output logic [PTR_W-1:0]  rd_addr
);

	localparam logic [PTR_W-1:0] LAST = PTR_W'(BUF_DEPTH - 1);

	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic              shift_q;
	logic              caps_q;

	logic [6:0]        code;
	logic              release_code;
	logic              is_read;
	logic              is_shift;
	logic              is_caps;
	logic [CHAR_W-1:0] ch;
	logic [PTR_W-1:0]  rd_ptr_nxt;
	logic [PTR_W-1:0]  wr_ptr_nxt;
	logic              empty;
	logic              full;
	logic              is_char;
	logic              pop;
	logic              push;

	assign code         = scan_byte[6:0];
	assign release_code = (scan_byte[7] == SC_RELEASE_BIT);
	assign is_read      = (op_t'(opcode) == OP_READ);
	assign is_shift     = (code == SC_LSHIFT) || (code == SC_RSHIFT);
	assign is_caps      = (code == SC_CAPS);
	assign ch           = keymap(code, shift_q ^ caps_q);

	assign rd_ptr_nxt = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
	assign wr_ptr_nxt = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
	assign empty      = (rd_ptr_q == wr_ptr_q);
	// One slot always stays free, so full means the writer would catch the reader.
	assign full       = (wr_ptr_nxt == rd_ptr_q);

	assign is_char = !is_read && !release_code && !is_shift && !is_caps && (ch != '0);
	assign pop     = is_read && !empty;
	assign push    = is_char && !full;

	always_comb begin
		flags.char_valid   = pop;
		flags.char_dropped = is_char && full;
		if (pop) begin
			flags.buffer_nonempty = (rd_ptr_nxt != wr_ptr_q);
		end else if (push) begin
			flags.buffer_nonempty = 1'b1;
		end else begin
			flags.buffer_nonempty = !empty;
		end
	end

	assign wr_en   = advance && push;
	assign wr_addr = wr_ptr_q;
	assign wr_data = ch;
	assign rd_en   = advance && pop;
	assign rd_addr = rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			shift_q  <= 1'b0;
			caps_q   <= 1'b0;
		end else if (advance) begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_nxt;
			end
			if (push) begin
				wr_ptr_q <= wr_ptr_nxt;
			end
			if (!is_read && is_shift) begin
				shift_q <= !release_code;
			end
			// Caps lock toggles on its make code only; its release is ignored.
			if (!is_read && !release_code && is_caps) begin
				caps_q <= !caps_q;
			end
		end
	end

endmodule

>>> rtl/scancode_to_ascii_fifo_unit.sv
// Top level of the set-1 scancode to ASCII decoder with character FIFO.
// Each input word is either a raw set-1 scancode (opcode 0) or a request to pop one
// character (opcode 1); every input word yields exactly one result word. A new word
// is accepted in every cycle unless the read stage holds a result and the output is
// stalled: shift/caps tracking, the key table lookup and the ring pointer update all
// finish in the cycle of acceptance, and the character store is a RAM with a
// registered read port, so a result passes through the RAM read stage and then the
// output register before it leaves. The output register and the read stage together
// buffer two results, so input stays ready while a result waits in the output
// register alone. The FIFO holds at most BUF_DEPTH-1 characters; a character decoded
// while it is full is dropped and flagged. The store needs no clearing after reset.
module scancode_to_ascii_fifo_unit import scaf_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	scaf_in_if.sink          scan_in,
	scaf_out_if.source       char_out
);

	localparam int PTR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	logic              accept;
	logic              s1_move;
	logic              valid_s1;
	step_flags_t       flags_s1;
	step_flags_t       flags;
	logic              out_valid_q;
	step_flags_t       out_flags_q;
	logic [CHAR_W-1:0] out_char_q;

	logic              wr_en;
	logic [PTR_W-1:0]  wr_addr;
	logic [CHAR_W-1:0] wr_data;
	logic              rd_en;
	logic [PTR_W-1:0]  rd_addr;
	logic [CHAR_W-1:0] rd_data;

	assign s1_move       = !out_valid_q || char_out.ready;
	assign scan_in.ready = !valid_s1 || s1_move;
	assign accept        = scan_in.valid && scan_in.ready;

	scaf_engine #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (accept),
		.opcode    (scan_in.opcode),
		.scan_byte (scan_in.scan_byte),
		.flags     (flags),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr)
	);

	// The read data holds while the read stage is stalled, since a new read is
	// only issued when a word is accepted.
	scaf_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (BUF_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (scan_in.ready) begin
				valid_s1 <= accept;
			end
			if (s1_move) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1 <= flags;
		end
		if (s1_move && valid_s1) begin
			out_flags_q <= flags_s1;
			out_char_q  <= flags_s1.char_valid ? rd_data : '0;
		end
	end

	assign char_out.valid           = out_valid_q;
	assign char_out.char_valid      = out_flags_q.char_valid;
	assign char_out.char_code       = out_char_q;
	assign char_out.buffer_nonempty = out_flags_q.buffer_nonempty;
	assign char_out.char_dropped    = out_flags_q.char_dropped;

endmodule

>>> rtl/scaf_checker.sv
// Port-level assertions for the scancode FIFO unit, bound to its top level.
`include "assert_macros.svh"

module scaf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       char_valid,
	input logic [6:0] char_code,
	input logic       buffer_nonempty,
	input logic       char_dropped
);

	// A stalled result keeps its content until it is taken.
	`ASSERT_PROP(a_out_hold,
		(out_valid && !out_ready) |=> (out_valid && $stable(char_code) && $stable(char_valid)),
		"stalled result changed")

	// Input back-pressure only arises from a stalled output.
	`ASSERT_IMPLIES(a_ready_cause, !in_ready, out_valid && !out_ready,
		"input stalled without output stall")

	`ASSERT_IMPLIES(a_code_zero, out_valid && !char_valid, char_code == 7'h0,
		"char_code nonzero without character")

	// A drop means the buffer was full, so it cannot be empty and no pop happened.
	`ASSERT_IMPLIES(a_drop_full, out_valid && char_dropped, buffer_nonempty && !char_valid,
		"drop reported with empty buffer or pop")

endmodule

bind scancode_to_ascii_fifo_unit scaf_checker u_scaf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (scan_in.ready),
	.out_valid       (char_out.valid),
	.out_ready       (char_out.ready),
	.char_valid      (char_out.char_valid),
	.char_code       (char_out.char_code),
	.buffer_nonempty (char_out.buffer_nonempty),
	.char_dropped    (char_out.char_dropped)
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the scancode to ASCII decoder with its character FIFO.

typedef struct packed {
	logic       char_valid;
	logic [6:0] char_code;
	logic       buffer_nonempty;
	logic       char_dropped;
} char_result_t;

class scan_decode_scoreboard;
	localparam int KEY_ROWS = 58;

	logic [6:0]   plain_keys[KEY_ROWS];
	logic [6:0]   shifted_keys[KEY_ROWS];
	logic [6:0]   buffered_chars[$];
	char_result_t expected_results[$];
	bit           shift_down;
	bit           caps_on;
	int           ring_size;
	int           errors;
	int           checked;
	int           pops;
	int           empty_reads;
	int           drops;

	function new(int depth);
		ring_size = depth;
		plain_keys = '{
			7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
			7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
			7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
			7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
			7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
			7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
			7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
			7'h00, 7'h20};
		shifted_keys = '{
			7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
			7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
			7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
			7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
			7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
			7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
			7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
			7'h00, 7'h20};
	endfunction

	// Applies one accepted input word to the decoder state and queues its result.
	function void note_word(scaf_pkg::op_t op, logic [7:0] sc);
		char_result_t r;
		logic [6:0]   key;
		logic [6:0]   ch;
		bit           is_shift;
		r = '0;
		key = sc[6:0];
		is_shift = (key == scaf_pkg::SC_LSHIFT) || (key == scaf_pkg::SC_RSHIFT);
		if (op == scaf_pkg::OP_READ) begin
			if (buffered_chars.size() != 0) begin
				r.char_valid = 1'b1;
				r.char_code = buffered_chars.pop_front();
				pops++;
			end else begin
				empty_reads++;
			end
		end else if (sc[7] == scaf_pkg::SC_RELEASE_BIT) begin
			// Only shift releases matter; the caps key acts on its make code alone.
			if (is_shift)
				shift_down = 1'b0;
		end else if (is_shift) begin
			shift_down = 1'b1;
		end else if (key == scaf_pkg::SC_CAPS) begin
			caps_on = !caps_on;
		end else begin
			ch = 7'h00;
			if (key < KEY_ROWS)
				ch = (shift_down ^ caps_on) ? shifted_keys[key] : plain_keys[key];
			if (ch != 7'h00) begin
				// The ring keeps one slot free, so it holds one less than its size.
				if (buffered_chars.size() < ring_size - 1) begin
					buffered_chars.push_back(ch);
				end else begin
					r.char_dropped = 1'b1;
					drops++;
				end
			end
		end
		r.buffer_nonempty = (buffered_chars.size() != 0);
		expected_results.push_back(r);
	endfunction

	function void check_result(char_result_t got);
		char_result_t want;
		if (expected_results.size() == 0) begin
			$error("result word with no input outstanding: %p", got);
			errors++;
			return;
		end
		want = expected_results.pop_front();
		checked++;
		if (got.char_valid !== want.char_valid) begin
			$error("char_valid: expected %0d, actual %0d", want.char_valid, got.char_valid);
			errors++;
		end
		if (got.char_code !== want.char_code) begin
			$error("char_code: expected 0x%02h, actual 0x%02h", want.char_code, got.char_code);
			errors++;
		end
		if (got.buffer_nonempty !== want.buffer_nonempty) begin
			$error("buffer_nonempty: expected %0d, actual %0d",
				want.buffer_nonempty, got.buffer_nonempty);
			errors++;
		end
		if (got.char_dropped !== want.char_dropped) begin
			$error("char_dropped: expected %0d, actual %0d",
				want.char_dropped, got.char_dropped);
			errors++;
		end
	endfunction

	function int pending();
		return expected_results.size();
	endfunction
endclass

module tb;
	import scaf_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 10;

	typedef enum int {
		RECV_FREE,
		RECV_RANDOM,
		RECV_PATTERN
	} recv_mode_t;

	logic clk;
	logic arst_n;

	scaf_in_if  scan_in();
	scaf_out_if char_out();

	scancode_to_ascii_fifo_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan_in  (scan_in),
		.char_out (char_out)
	);

	scan_decode_scoreboard sb;
	int         burst_left;
	int         words_sent;
	int         idle_cycles;
	recv_mode_t recv_mode;
	logic [7:0] recv_mask;
	int         recv_left;
	int         recv_phase;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver switches between free flow, random stalls and a repeating mask.
	always @(negedge clk) begin
		if (!arst_n) begin
			char_out.ready = 1'b0;
		end else begin
			if (recv_left == 0) begin
				recv_mode = recv_mode_t'($urandom_range(2));
				recv_mask = 8'($urandom_range(255));
				recv_left = $urandom_range(80, 20);
			end
			recv_left--;
			recv_phase = (recv_phase + 1) % 8;
			case (recv_mode)
				RECV_FREE:   char_out.ready = 1'b1;
				RECV_RANDOM: char_out.ready = ($urandom_range(99) >= 35);
				default:     char_out.ready = recv_mask[recv_phase];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && char_out.valid && char_out.ready)
			sb.check_result('{char_out.char_valid, char_out.char_code,
				char_out.buffer_nonempty, char_out.char_dropped});
	end

	always @(posedge clk) begin
		if (!arst_n || (scan_in.valid && scan_in.ready) || (char_out.valid && char_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("scancode_to_ascii_fifo_unit: mismatch");
			$finish;
		end
	end

	// Sends one word, opening a new burst after a random gap when the last one ran out.
	task automatic send_word(input op_t op, input logic [7:0] sc);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(40, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
			if (gap > 0) begin
				@(negedge clk);
				scan_in.valid = 1'b0;
				scan_in.opcode = 1'($urandom_range(1));
				scan_in.scan_byte = 8'($urandom_range(255));
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		scan_in.valid = 1'b1;
		scan_in.opcode = op;
		scan_in.scan_byte = sc;
		@(posedge clk);
		while (!scan_in.ready)
			@(posedge clk);
		sb.note_word(op, sc);
		words_sent++;
	endtask

	// Mostly keys that carry a character, with shift and caps traffic and raw noise.
	function automatic logic [7:0] random_scan(int key_pct);
		int roll;
		roll = $urandom_range(99);
		if (roll < key_pct)
			return {1'b0, 7'($urandom_range(8'h39, 1))};
		roll = $urandom_range(99);
		if (roll < 40)
			return {1'($urandom_range(1)), ($urandom_range(1) != 0) ? SC_LSHIFT : SC_RSHIFT};
		if (roll < 55)
			return {1'($urandom_range(1)), SC_CAPS};
		return 8'($urandom_range(255));
	endfunction

	task automatic type_words(input int count, input int read_pct, input int key_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < read_pct)
				send_word(OP_READ, 8'($urandom_range(255)));
			else
				send_word(OP_SCAN, random_scan(key_pct));
		end
	endtask

	initial begin
		sb = new(BUF_DEPTH_DEF);
		arst_n = 1'b0;
		scan_in.valid = 1'b0;
		scan_in.opcode = OP_SCAN;
		scan_in.scan_byte = 8'h00;
		char_out.ready = 1'b0;
		burst_left = 0;
		words_sent = 0;
		idle_cycles = 0;
		recv_left = 0;
		recv_phase = 0;
		recv_mode = RECV_FREE;
		recv_mask = 8'hFF;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reads on an empty buffer, then character keys with shift, caps and ignored codes, then two reads.
		send_word(OP_READ, 8'h00);
		send_word(OP_READ, 8'hFF);
		send_word(OP_SCAN, 8'h00);
		send_word(OP_SCAN, 8'h1E);
		send_word(OP_SCAN, {1'b0, SC_LSHIFT});
		send_word(OP_SCAN, 8'h1E);
		send_word(OP_SCAN, 8'h02);
		send_word(OP_SCAN, {SC_RELEASE_BIT, SC_LSHIFT});
		send_word(OP_SCAN, {1'b0, SC_RSHIFT});
		send_word(OP_SCAN, 8'h39);
		send_word(OP_SCAN, {SC_RELEASE_BIT, SC_RSHIFT});
		send_word(OP_SCAN, {1'b0, SC_CAPS});
		send_word(OP_SCAN, {SC_RELEASE_BIT, SC_CAPS});
		send_word(OP_SCAN, 8'h10);
		send_word(OP_SCAN, 8'h02);
		send_word(OP_SCAN, {1'b0, SC_LSHIFT});
		send_word(OP_SCAN, 8'h10);
		send_word(OP_SCAN, {SC_RELEASE_BIT, SC_LSHIFT});
		send_word(OP_SCAN, {1'b0, SC_CAPS});
		send_word(OP_SCAN, 8'h9E);
		send_word(OP_SCAN, 8'h7F);
		send_word(OP_SCAN, 8'h1D);
		send_word(OP_SCAN, 8'h80);
		send_word(OP_READ, 8'h55);
		send_word(OP_READ, 8'hAA);

		// Mixed traffic, then a long typing stretch that overruns the buffer,
		// then mostly reads until it runs dry.
		type_words(130, 40, 60);
		type_words(420, 5, 90);
		type_words(300, 95, 50);

		@(negedge clk);
		scan_in.valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words and checked %0d results: %0d characters popped, %0d empty reads.",
			words_sent, sb.checked, sb.pops, sb.empty_reads);
		$display("%0d characters were dropped on a full buffer with shift and caps in play.",
			sb.drops);
		if (sb.errors == 0)
			$display("scancode_to_ascii_fifo_unit: match");
		else
			$display("scancode_to_ascii_fifo_unit: mismatch");
		$finish;
	end
endmodule
